[sv/pid_controller_step_macros.svh]
// ----------------------------------------------------------------------------
// pid_controller_step_macros
// Assertion macros for the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// clocked assertion, switched off while reset is high
`define PIDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define PIDC_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Widths, register map and defaults shared by the controller files.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // sample and result field widths
  localparam int unsigned PIDC_MEAS_W     = 16;
  localparam int unsigned PIDC_TICK_W     = 16;
  localparam int unsigned PIDC_OUT_W      = 32;

  // magnitude of a gain times an error or measurement change
  localparam int unsigned PIDC_PROD_W     = 48;

  // quotient bits retired per divider cycle
  localparam int unsigned PIDC_DIV_STEPS  = 4;

  // configuration port
  localparam int unsigned PIDC_CFG_IDX_W  = 3;
  localparam int unsigned PIDC_CFG_DATA_W = 32;

  typedef enum logic [PIDC_CFG_IDX_W-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEG_GAIN       = 3'd1,
    REG_DERIV_GAIN       = 3'd2,
    REG_TARGET_VALUE     = 3'd3,
    REG_SUM_UPPER_LIMIT  = 3'd4,
    REG_INTEG_TERM_LIMIT = 3'd5,
    REG_RAMP_LIMIT       = 3'd6,
    REG_USE_ELAPSED      = 3'd7
  } pidc_reg_t;

endpackage

[sv/pidc_sample_if.sv]
// ----------------------------------------------------------------------------
// pidc_sample_if
// Sample channel: command, measurement and elapsed ticks.
// ----------------------------------------------------------------------------
interface pidc_sample_if import pidc_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [PIDC_MEAS_W-1:0] measured_value;
  logic [PIDC_TICK_W-1:0]        elapsed_ticks;

  modport source (output valid, output cmd, output measured_value,
                  output elapsed_ticks, input ready);
  modport sink   (input valid, input cmd, input measured_value,
                  input elapsed_ticks, output ready);
endinterface

[sv/pidc_result_if.sv]
// ----------------------------------------------------------------------------
// pidc_result_if
// Result channel: drive value and saturation flag.
// ----------------------------------------------------------------------------
interface pidc_result_if import pidc_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [PIDC_OUT_W-1:0] control_output;
  logic                         output_saturated;

  modport source (output valid, output control_output, output output_saturated,
                  input ready);
  modport sink   (input valid, input control_output, input output_saturated,
                  output ready);
endinterface

[sv/pidc_cfg_if.sv]
// ----------------------------------------------------------------------------
// pidc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pidc_cfg_if import pidc_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [PIDC_CFG_IDX_W-1:0]  index;
  logic [PIDC_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/pid_controller_step.sv]
// ----------------------------------------------------------------------------
// pid_controller_step
// PID controller step in Q16.16 with integrator bound, I-term clamp, ramp
// limit and output saturation.
// ----------------------------------------------------------------------------
// A sample beat makes five passes through one shared 32x32 multiplier (P
// term, integral gain times elapsed, two halves of the I term, D numerator),
// then the divider forms the D term, 4 quotient bits per cycle by default,
// plus the sum and clamp steps; a clear beat goes straight to the result.
// One beat is worked on at a time; sample ready is high only while the
// sequencer is idle, and a finished result waits in the output register, so
// a new sample can be taken while the last result is unread.
// Configuration writes are taken at any time but must be made while idle.
module pid_controller_step import pidc_pkg::*; #(
  parameter int unsigned DIV_STEPS = PIDC_DIV_STEPS
) (
  input logic           clk,
  input logic           rst,
  pidc_sample_if.sink   sample,
  pidc_result_if.source result,
  pidc_cfg_if.sink      cfg
);

  localparam logic [62:0] TERM_LIMIT = 63'h4000_0000_0000_0000;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0_0000_0000_0001,
    ST_MUL_P    = 13'b0_0000_0000_0010,
    ST_MUL_GE   = 13'b0_0000_0000_0100,
    ST_MUL_ILO  = 13'b0_0000_0000_1000,
    ST_MUL_IHI  = 13'b0_0000_0001_0000,
    ST_MUL_D    = 13'b0_0000_0010_0000,
    ST_IMAG     = 13'b0_0000_0100_0000,
    ST_ICLAMP   = 13'b0_0000_1000_0000,
    ST_SUM_PI   = 13'b0_0001_0000_0000,
    ST_DIV_WAIT = 13'b0_0010_0000_0000,
    ST_SUM_D    = 13'b0_0100_0000_0000,
    ST_RAMP     = 13'b0_1000_0000_0000,
    ST_FINISH   = 13'b1_0000_0000_0000
  } pidc_state_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] n;
    n = ~v + 32'd1;
    return v[31] ? n : v;
  endfunction

  function automatic logic [15:0] mag17(input logic [16:0] v);
    logic [16:0] n;
    n = ~v + 17'd1;
    return v[16] ? n[15:0] : v[15:0];
  endfunction

  pidc_state_t state;
  pidc_state_t state_next;

  // configuration registers
  logic signed [31:0]            prop_gain;
  logic signed [31:0]            integ_gain;
  logic signed [31:0]            deriv_gain;
  logic signed [PIDC_MEAS_W-1:0] target_value;
  logic [30:0]                   sum_upper_limit;
  logic [30:0]                   integ_term_limit;
  logic [30:0]                   ramp_limit;
  logic                          use_elapsed;

  // controller history
  logic signed [31:0]            error_accumulator;
  logic signed [PIDC_MEAS_W-1:0] previous_measurement;
  logic signed [PIDC_OUT_W-1:0]  previous_output;

  // per-beat working registers
  logic signed [PIDC_MEAS_W-1:0] meas;
  logic [PIDC_TICK_W-1:0]        elapsed;
  logic [16:0]                   err;
  logic [16:0]                   dm;
  logic [PIDC_PROD_W-1:0]        p_mag;
  logic [15:0]                   ge_hi;
  logic [63:0]                   ilo;
  logic [47:0]                   ihi;
  logic [62:0]                   i_mag;
  logic signed [32:0]            ramp_hi;
  logic signed [32:0]            ramp_lo;
  logic signed [63:0]            s_val;
  logic                          hit;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_prod;

  // divider
  logic                   div_busy;
  logic [PIDC_PROD_W-1:0] div_quo;

  // result register
  logic                         out_valid;
  logic signed [PIDC_OUT_W-1:0] out_value;
  logic                         out_sat;

  logic                         accept;
  logic                         out_free;
  logic [31:0]                  acc_mag;
  logic signed [32:0]           acc_sum;
  logic signed [32:0]           acc_lim;
  logic signed [31:0]           acc_next;
  logic [64:0]                  i_sum;
  logic                         i_over;
  logic [62:0]                  i_clip;
  logic [63:0]                  i_pos;
  logic [63:0]                  p_pos;
  logic [63:0]                  d_pos;
  logic                         sat_hi;
  logic                         sat_lo;
  logic signed [PIDC_OUT_W-1:0] out_next;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign out_free     = !out_valid || result.ready;
  assign cfg.ready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= '0;
      integ_gain       <= '0;
      deriv_gain       <= '0;
      target_value     <= '0;
      sum_upper_limit  <= '0;
      integ_term_limit <= '0;
      ramp_limit       <= '0;
      use_elapsed      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (pidc_reg_t'(cfg.index))
        REG_PROP_GAIN:        prop_gain        <= cfg.data;
        REG_INTEG_GAIN:       integ_gain       <= cfg.data;
        REG_DERIV_GAIN:       deriv_gain       <= cfg.data;
        REG_TARGET_VALUE:     target_value     <= cfg.data[PIDC_MEAS_W-1:0];
        REG_SUM_UPPER_LIMIT:  sum_upper_limit  <= cfg.data[30:0];
        REG_INTEG_TERM_LIMIT: integ_term_limit <= cfg.data[30:0];
        REG_RAMP_LIMIT:       ramp_limit       <= cfg.data[30:0];
        REG_USE_ELAPSED:      use_elapsed      <= cfg.data[0];
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sample.cmd ? ST_FINISH : ST_MUL_P;
        end
      end
      ST_MUL_P:    state_next = ST_MUL_GE;
      ST_MUL_GE:   state_next = ST_MUL_ILO;
      ST_MUL_ILO:  state_next = ST_MUL_IHI;
      ST_MUL_IHI:  state_next = ST_MUL_D;
      ST_MUL_D:    state_next = ST_IMAG;
      ST_IMAG:     state_next = ST_ICLAMP;
      ST_ICLAMP:   state_next = ST_SUM_PI;
      ST_SUM_PI:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = ST_SUM_D;
        end
      end
      ST_SUM_D:    state_next = ST_RAMP;
      ST_RAMP:     state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier operand select, product registered every cycle
  assign acc_mag = mag32(error_accumulator);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_P: begin
        mul_a = mag32(prop_gain);
        mul_b = {16'b0, mag17(err)};
      end
      ST_MUL_GE: begin
        mul_a = mag32(integ_gain);
        mul_b = {16'b0, elapsed};
      end
      ST_MUL_ILO: begin
        mul_a = mul_prod[31:0];
        mul_b = acc_mag;
      end
      ST_MUL_IHI: begin
        mul_a = {16'b0, ge_hi};
        mul_b = acc_mag;
      end
      ST_MUL_D: begin
        mul_a = mag32(deriv_gain);
        mul_b = {16'b0, mag17(dm)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_prod <= {32'b0, mul_a} * {32'b0, mul_b};
  end

  // D numerator divided by elapsed ticks
  pidc_div #(
    .QUOT_W (PIDC_PROD_W),
    .STEPS  (DIV_STEPS),
    .DIVR_W (PIDC_TICK_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_IMAG),
    .dividend (mul_prod[PIDC_PROD_W-1:0]),
    .divisor  (elapsed),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // integrator: add error, upper bound when set, then 32-bit saturation
  always_comb begin
    acc_sum = {error_accumulator[31], error_accumulator} + {{16{err[16]}}, err};
    if (sum_upper_limit != '0 && acc_sum > $signed({2'b00, sum_upper_limit})) begin
      acc_lim = $signed({2'b00, sum_upper_limit});
    end else begin
      acc_lim = acc_sum;
    end
    if (!acc_lim[32] && acc_lim[31]) begin
      acc_next = 32'sh7FFF_FFFF;
    end else if (acc_lim[32] && !acc_lim[31]) begin
      acc_next = 32'sh8000_0000;
    end else begin
      acc_next = acc_lim[31:0];
    end
  end

  // I magnitude from the two partial products, saturated at the term limit
  assign i_sum  = {1'b0, ilo} + {3'b000, ihi[29:0], 32'h0};
  assign i_over = (ihi[47:30] != '0) || (i_sum > {2'b00, TERM_LIMIT});

  // symmetric I clamp applied to the magnitude
  always_comb begin
    logic [62:0] lim;
    lim = {32'b0, integ_term_limit};
    if (integ_term_limit != '0 && i_mag > lim) begin
      i_clip = lim;
    end else begin
      i_clip = i_mag;
    end
  end

  assign i_pos = {1'b0, i_clip};
  assign p_pos = {16'b0, p_mag};
  assign d_pos = {16'b0, div_quo};

  // final 32-bit saturation
  assign sat_hi   = !s_val[63] && (s_val[62:31] != '0);
  assign sat_lo   = s_val[63] && (s_val[62:31] != '1);
  assign out_next = sat_hi ? 32'sh7FFF_FFFF :
                    sat_lo ? 32'sh8000_0000 : s_val[31:0];

  // controller history
  always_ff @(posedge clk) begin
    if (rst) begin
      error_accumulator    <= '0;
      previous_measurement <= '0;
      previous_output      <= '0;
    end else begin
      if (accept && sample.cmd) begin
        error_accumulator <= '0;
      end else if (state == ST_MUL_P) begin
        error_accumulator <= acc_next;
      end
      if (state == ST_FINISH && out_free) begin
        previous_measurement <= meas;
        previous_output      <= out_next;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          hit <= 1'b0;
          if (sample.cmd) begin
            meas  <= '0;
            s_val <= '0;
          end else begin
            meas    <= sample.measured_value;
            elapsed <= (use_elapsed && sample.elapsed_ticks != '0) ?
                       sample.elapsed_ticks : PIDC_TICK_W'(1);
            err     <= {target_value[15], target_value} -
                       {sample.measured_value[15], sample.measured_value};
            dm      <= {sample.measured_value[15], sample.measured_value} -
                       {previous_measurement[15], previous_measurement};
          end
        end
      end
      ST_MUL_P: begin
        ramp_hi <= {previous_output[31], previous_output} + {2'b00, ramp_limit};
        ramp_lo <= {previous_output[31], previous_output} - {2'b00, ramp_limit};
      end
      ST_MUL_GE:  p_mag <= mul_prod[PIDC_PROD_W-1:0];
      ST_MUL_ILO: ge_hi <= mul_prod[47:32];
      ST_MUL_IHI: ilo   <= mul_prod;
      ST_MUL_D:   ihi   <= mul_prod[47:0];
      ST_IMAG:    i_mag <= i_over ? TERM_LIMIT : i_sum[62:0];
      ST_ICLAMP: begin
        s_val <= (integ_gain[31] ^ error_accumulator[31]) ? (~i_pos + 64'd1) : i_pos;
      end
      ST_SUM_PI: begin
        s_val <= s_val + ((prop_gain[31] ^ err[16]) ? (~p_pos + 64'd1) : p_pos);
      end
      ST_DIV_WAIT: ;
      ST_SUM_D: begin
        s_val <= s_val - ((deriv_gain[31] ^ dm[16]) ? (~d_pos + 64'd1) : d_pos);
      end
      ST_RAMP: begin
        if (ramp_limit != '0) begin
          if (s_val > $signed({{31{ramp_hi[32]}}, ramp_hi})) begin
            s_val <= {{31{ramp_hi[32]}}, ramp_hi};
            hit   <= 1'b1;
          end else if (s_val < $signed({{31{ramp_lo[32]}}, ramp_lo})) begin
            s_val <= {{31{ramp_lo[32]}}, ramp_lo};
            hit   <= 1'b1;
          end
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_value <= out_next;
      out_sat   <= hit || sat_hi || sat_lo;
    end
  end

  assign result.valid            = out_valid;
  assign result.control_output   = out_value;
  assign result.output_saturated = out_sat;

endmodule

[sv/pidc_div.sv]
// ----------------------------------------------------------------------------
// pidc_div
// Unsigned restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; #(
  parameter int unsigned QUOT_W = PIDC_PROD_W,
  parameter int unsigned STEPS  = PIDC_DIV_STEPS,
  parameter int unsigned DIVR_W = PIDC_TICK_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quotient
);

  localparam int unsigned ITERS = (QUOT_W + STEPS - 1) / STEPS;
  localparam int unsigned PAD_W = ITERS * STEPS;
  localparam int unsigned CNT_W = $clog2(ITERS + 1);

  typedef logic [PAD_W-1:0] pad_t;
  typedef logic [CNT_W-1:0] cnt_t;

  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] rem_next;
  pad_t              quo;
  pad_t              quo_next;
  logic [DIVR_W-1:0] dvsr;
  cnt_t              cnt;

  // one cycle of compare and subtract steps, dividend bits shift out on top
  always_comb begin
    logic [DIVR_W:0] shifted;
    logic [DIVR_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < STEPS; k++) begin
      shifted = {rem_next, quo_next[PAD_W-1]};
      trial   = shifted - {1'b0, dvsr};
      if (!trial[DIVR_W]) begin
        rem_next = trial[DIVR_W-1:0];
        quo_next = {quo_next[PAD_W-2:0], 1'b1};
      end else begin
        rem_next = shifted[DIVR_W-1:0];
        quo_next = {quo_next[PAD_W-2:0], 1'b0};
      end
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= cnt_t'(ITERS);
    end else if (busy) begin
      cnt <= cnt - cnt_t'(1);
      if (cnt == cnt_t'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= pad_t'(dividend);
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo[QUOT_W-1:0];

endmodule

[sv/pidc_checker.sv]
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "pid_controller_step_macros.svh"

module pidc_checker import pidc_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [PIDC_OUT_W-1:0] control_output,
  input logic                         output_saturated
);

  // no result is pending right after reset
  `PIDC_ASSERT_NORST(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

  // an accepted sample keeps the block busy in the following cycle
  `PIDC_ASSERT_NORST(a_busy_after_beat, clk, (!rst && in_valid && in_ready) |=> !in_ready, "sample taken while busy")

  // a stalled result stays offered
  `PIDC_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

  // a stalled result does not change
  `PIDC_ASSERT(a_out_stable, clk, rst, (out_valid && !out_ready) |=> ($stable(control_output) && $stable(output_saturated)), "result changed while stalled")

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (sample.valid),
  .in_ready         (sample.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .control_output   (result.control_output),
  .output_saturated (result.output_saturated)
);

[verif/pid_controller_step_tb.sv]
// ----------------------------------------------------------------------------
// pid_controller_step_tb
// Self-checking bench for the Q16.16 PID step. Samples and clears are queued
// by a stimulus process and fed by a clocked driver; every accepted sample is
// run through a shadow controller, and each result beat is compared with the
// oldest forecast drive value and saturation flag. Configuration is rewritten
// between phases, with random idling, a long result hold-off and a clean tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pid_controller_step_tb import pidc_pkg::*;;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;
  localparam longint TERM_CAP = 64'sh4000_0000_0000_0000;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_COUNT  = 12;
  localparam int unsigned PHASE_ITEMS  = 124;
  localparam int unsigned PRESSURE_PH  = 5;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned REPORT_LINES = 40;

  typedef struct packed {
    logic                          cmd;
    logic signed [PIDC_MEAS_W-1:0] meas;
    logic [PIDC_TICK_W-1:0]        ticks;
  } sample_t;

  typedef struct packed {
    logic signed [PIDC_OUT_W-1:0] value;
    logic                         sat;
  } drive_t;

  typedef struct packed {
    pidc_reg_t                  idx;
    logic [PIDC_CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pidc_sample_if smp_bus ();
  pidc_result_if res_bus ();
  pidc_cfg_if    cfg_bus ();

  pid_controller_step i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers
  logic signed [31:0]            kp = '0;
  logic signed [31:0]            ki = '0;
  logic signed [31:0]            kd = '0;
  logic signed [PIDC_MEAS_W-1:0] setpoint = '0;
  logic [30:0]                   sum_cap = '0;
  logic [30:0]                   iterm_cap = '0;
  logic [30:0]                   slew_cap = '0;
  logic                          elapsed_en = 1'b0;

  // shadow controller state
  longint err_sum = 0;
  longint last_meas = 0;
  longint last_drive = 0;

  sample_t    sample_backlog[$];
  reg_write_t reg_writes[$];
  drive_t     drive_forecast[$];

  sample_t    sample_held;
  reg_write_t write_held;
  int         sample_gap;
  int         result_stall;
  int         mismatch_count = 0;
  bit         idle_mode = 1'b1;
  bit         hold_go = 1'b0;
  logic       hold_on = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi, inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void shadow_write(reg_write_t w);
    case (w.idx)
      REG_PROP_GAIN:        kp = w.data;
      REG_INTEG_GAIN:       ki = w.data;
      REG_DERIV_GAIN:       kd = w.data;
      REG_TARGET_VALUE:     setpoint = w.data[PIDC_MEAS_W-1:0];
      REG_SUM_UPPER_LIMIT:  sum_cap = w.data[30:0];
      REG_INTEG_TERM_LIMIT: iterm_cap = w.data[30:0];
      REG_RAMP_LIMIT:       slew_cap = w.data[30:0];
      REG_USE_ELAPSED:      elapsed_en = w.data[0];
      default: ;
    endcase
  endfunction

  // one controller step on the shadow state
  function automatic drive_t predict_drive(sample_t s);
    drive_t              r;
    longint              meas, e, err, p_term, acc, i_term, d_term, total;
    logic signed [127:0] ki_e, acc_w, prod;
    bit                  hit, unused;
    r.sat  = 1'b0;
    r.value = '0;
    hit    = 1'b0;
    unused = 1'b0;
    if (s.cmd == CMD_CLEAR) begin
      err_sum    = 0;
      last_meas  = 0;
      last_drive = 0;
      return r;
    end
    meas = longint'(s.meas);
    e = (elapsed_en && s.ticks != '0) ? longint'(s.ticks) : 64'sd1;
    err = longint'(setpoint) - meas;
    p_term = longint'(kp) * err;

    // integrator: upper bound only, then 32-bit saturation
    acc = err_sum + err;
    if (sum_cap != '0 && acc > longint'(sum_cap))
      acc = longint'(sum_cap);
    acc = clip(acc, INT32_LO, INT32_HI, unused);
    err_sum = acc;

    // i term, exact product held to +-2^62, then optional symmetric clamp
    ki_e  = 128'(longint'(ki) * e);
    acc_w = 128'(acc);
    prod  = ki_e * acc_w;
    if (prod > 128'(TERM_CAP))
      i_term = TERM_CAP;
    else if (prod < -128'(TERM_CAP))
      i_term = -TERM_CAP;
    else
      i_term = longint'(prod);
    if (iterm_cap != '0)
      i_term = clip(i_term, -longint'(iterm_cap), longint'(iterm_cap), unused);

    d_term = (longint'(kd) * (meas - last_meas)) / e;
    total = p_term + i_term - d_term;
    if (slew_cap != '0)
      total = clip(total, last_drive - longint'(slew_cap),
                   last_drive + longint'(slew_cap), hit);
    total = clip(total, INT32_LO, INT32_HI, hit);

    last_drive = total;
    last_meas  = meas;
    r.value = total[31:0];
    r.sat   = hit;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("%0t: %s got %0d, want %0d", $time, field, got, want);
  endtask

  // sample driver: holds a beat until taken, optional gap after each beat
  always @(posedge clk) begin
    if (rst) begin
      smp_bus.valid <= 1'b0;
      sample_gap = 0;
    end else begin
      if (smp_bus.valid && smp_bus.ready)
        drive_forecast.push_back(predict_drive(sample_held));
      if (!smp_bus.valid || smp_bus.ready) begin
        if (sample_gap != 0) begin
          sample_gap--;
          smp_bus.valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          sample_held = sample_backlog.pop_front();
          smp_bus.valid          <= 1'b1;
          smp_bus.cmd            <= sample_held.cmd;
          smp_bus.measured_value <= sample_held.meas;
          smp_bus.elapsed_ticks  <= sample_held.ticks;
          if (idle_mode && $urandom_range(0, 7) == 0)
            sample_gap = $urandom_range(1, 16);
        end else begin
          smp_bus.valid <= 1'b0;
        end
      end
    end
  end

  // configuration driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_bus.valid <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready)
        shadow_write(write_held);
      if (!cfg_bus.valid || cfg_bus.ready) begin
        if (reg_writes.size() != 0) begin
          write_held = reg_writes.pop_front();
          cfg_bus.valid <= 1'b1;
          cfg_bus.index <= write_held.idx;
          cfg_bus.data  <= write_held.data;
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (drive_forecast.size() == 0) begin
          report_mismatch("unexpected result beat", longint'(res_bus.control_output), 0);
        end else begin
          drive_t want;
          want = drive_forecast.pop_front();
          if (res_bus.control_output !== want.value)
            report_mismatch("control_output", longint'(res_bus.control_output),
                            longint'(want.value));
          if (res_bus.output_saturated !== want.sat)
            report_mismatch("output_saturated", longint'(res_bus.output_saturated),
                            longint'(want.sat));
        end
      end
      if (result_stall != 0)
        result_stall--;
      else if (idle_mode && $urandom_range(0, 9) == 0)
        result_stall = $urandom_range(1, 16);
      res_bus.ready <= !hold_on && result_stall == 0;
    end
  end

  // long result hold-off so the block backs up into its sample port
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic queue_write(pidc_reg_t idx, logic [31:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  task automatic queue_sample(logic cmd, int meas, int ticks);
    sample_t s;
    s.cmd   = cmd;
    s.meas  = meas[PIDC_MEAS_W-1:0];
    s.ticks = ticks[PIDC_TICK_W-1:0];
    sample_backlog.push_back(s);
  endtask

  // block is idle once every write and beat is through
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || smp_bus.valid || drive_forecast.size() != 0 ||
           reg_writes.size() != 0 || cfg_bus.valid);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2:       return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // unused top bit is filled at random
  function automatic logic [31:0] pick_limit(int unsigned small_max);
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1, 2:    v = $urandom_range(1, small_max);
      3:       v = 32'h7fff_ffff;
      default: v = $urandom & 32'h7fff_ffff;
    endcase
    v[31] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic queue_random_setup(output int centre);
    logic [31:0] tgt;
    tgt = $urandom;
    case ($urandom_range(0, 3))
      0:       tgt[15:0] = 16'h8000;
      1:       tgt[15:0] = 16'h7fff;
      2:       tgt[15:0] = 16'($urandom_range(0, 2000) - 1000);
      default: ;
    endcase
    centre = int'($signed(tgt[15:0]));
    queue_write(REG_PROP_GAIN, pick_gain());
    queue_write(REG_INTEG_GAIN, pick_gain());
    queue_write(REG_DERIV_GAIN, pick_gain());
    queue_write(REG_TARGET_VALUE, tgt);
    queue_write(REG_SUM_UPPER_LIMIT, pick_limit(5000));
    queue_write(REG_INTEG_TERM_LIMIT, pick_limit(32'h0010_0000));
    queue_write(REG_RAMP_LIMIT, pick_limit(32'h0008_0000));
    queue_write(REG_USE_ELAPSED, $urandom);
  endtask

  // mostly a measurement wandering near the setpoint, some noise and clears
  task automatic queue_random_samples(int unsigned count, int centre);
    int          level;
    int unsigned roll;
    sample_t     s;
    level = centre;
    repeat (count) begin
      roll    = $urandom_range(0, 99);
      s.cmd   = CMD_STEP;
      s.ticks = PIDC_TICK_W'($urandom_range(1, 64));
      if (roll < 3) begin
        s.cmd   = CMD_CLEAR;
        s.meas  = PIDC_MEAS_W'($urandom);
        s.ticks = PIDC_TICK_W'($urandom);
      end else if (roll < 10) begin
        s.meas  = PIDC_MEAS_W'($urandom);
        s.ticks = PIDC_TICK_W'($urandom);
      end else begin
        level = level + int'($urandom_range(0, 600)) - 300;
        if (level > 32767)
          level = 32767;
        if (level < -32768)
          level = -32768;
        s.meas = level[15:0];
        if (roll < 14)
          s.ticks = roll[0] ? '0 : '1;
      end
      sample_backlog.push_back(s);
    end
  endtask

  // stimulus
  initial begin
    int centre;
    smp_bus.valid          = 1'b0;
    smp_bus.cmd            = CMD_STEP;
    smp_bus.measured_value = '0;
    smp_bus.elapsed_ticks  = '0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_PROP_GAIN;
    cfg_bus.data           = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // moderate gains, field extremes, zero elapsed, clear
    queue_write(REG_PROP_GAIN, 32'h0001_0000);
    queue_write(REG_INTEG_GAIN, 32'h0000_8000);
    queue_write(REG_DERIV_GAIN, 32'h0002_0000);
    queue_write(REG_TARGET_VALUE, 32'h0000_0064);
    queue_write(REG_SUM_UPPER_LIMIT, 32'h0);
    queue_write(REG_INTEG_TERM_LIMIT, 32'h0);
    queue_write(REG_RAMP_LIMIT, 32'h0);
    queue_write(REG_USE_ELAPSED, 32'h1);
    wait_drained();
    queue_sample(CMD_STEP, 0, 1);
    queue_sample(CMD_STEP, 32767, 65535);
    queue_sample(CMD_STEP, -32768, 0);
    queue_sample(CMD_STEP, 50, 3);
    queue_sample(CMD_CLEAR, 0, 0);
    queue_sample(CMD_STEP, 100, 1);
    queue_sample(CMD_STEP, -32768, 1);
    queue_sample(CMD_STEP, 32767, 65535);
    wait_drained();

    // extreme gains and setpoint, elapsed ignored: output saturates low
    queue_write(REG_PROP_GAIN, 32'h7fff_ffff);
    queue_write(REG_INTEG_GAIN, 32'h7fff_ffff);
    queue_write(REG_DERIV_GAIN, 32'h8000_0000);
    queue_write(REG_TARGET_VALUE, 32'hffff_8000);
    queue_write(REG_SUM_UPPER_LIMIT, 32'h7fff_ffff);
    queue_write(REG_INTEG_TERM_LIMIT, 32'hffff_ffff);
    queue_write(REG_USE_ELAPSED, 32'hffff_fffe);
    wait_drained();
    queue_sample(CMD_STEP, 32767, 65535);
    queue_sample(CMD_STEP, -32768, 7);
    queue_sample(CMD_STEP, 32767, 1);
    wait_drained();

    // integrator upper bound, i term clamp, ramp limit; the sum carries over
    // negative from the last phase and has no lower bound, so it stays below the upper one
    queue_write(REG_PROP_GAIN, 32'h0001_0000);
    queue_write(REG_INTEG_GAIN, 32'h0001_0000);
    queue_write(REG_DERIV_GAIN, 32'h0);
    queue_write(REG_TARGET_VALUE, 32'h0);
    queue_write(REG_SUM_UPPER_LIMIT, 32'h8000_0032);
    queue_write(REG_INTEG_TERM_LIMIT, 32'h0020_0000);
    queue_write(REG_RAMP_LIMIT, 32'h0001_0000);
    queue_write(REG_USE_ELAPSED, 32'h1);
    wait_drained();
    queue_sample(CMD_STEP, -40, 1);
    queue_sample(CMD_STEP, -40, 1);
    queue_sample(CMD_STEP, -40, 1);
    queue_sample(CMD_STEP, 1000, 2);
    queue_sample(CMD_STEP, 1000, 1);
    queue_sample(CMD_STEP, 1000, 1);
    queue_sample(CMD_CLEAR, 0, 0);
    wait_drained();

    // random phases; one backs the block up, the last runs without idling
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_mode = (ph != PHASE_COUNT - 1) && (ph != PRESSURE_PH) &&
                  ($urandom_range(0, 3) != 0);
      queue_random_setup(centre);
      wait_drained();
      if (ph == PRESSURE_PH)
        hold_go = 1'b1;
      queue_random_samples(PHASE_ITEMS, centre);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_sample_if.sv
sv/pidc_result_if.sv
sv/pidc_cfg_if.sv
sv/pidc_div.sv
sv/pid_controller_step.sv
sv/pidc_checker.sv
verif/pid_controller_step_tb.sv
